// ===== hdl/frti_pkg.sv =====
`timescale 1ns / 1ps
package frti_pkg;
	localparam int unsigned ValueWidth = 64;
	localparam int unsigned OpWidth = 3;

	localparam logic [OpWidth-1:0] OP_NEAR_AWAY = 3'd0;
	localparam logic [OpWidth-1:0] OP_ZERO      = 3'd1;
	localparam logic [OpWidth-1:0] OP_AWAY      = 3'd2;
	localparam logic [OpWidth-1:0] OP_EVEN      = 3'd3;
	localparam logic [OpWidth-1:0] OP_ODD       = 3'd4;
	localparam logic [OpWidth-1:0] OP_CEIL      = 3'd5;
	localparam logic [OpWidth-1:0] OP_FLOOR     = 3'd6;

	// Decide whether the truncated magnitude steps up by one unit
	function automatic logic take_up(input logic [OpWidth-1:0] op, input logic neg,
			input logic above, input logic tie, input logic odd_lsb);
		logic up;
		case (op)
			OP_NEAR_AWAY: up = above | tie;
			OP_AWAY:      up = 1'b1;
			OP_EVEN:      up = above | (tie & odd_lsb);
			OP_ODD:       up = above | (tie & ~odd_lsb);
			OP_CEIL:      up = ~neg;
			OP_FLOOR:     up = neg;
			default:      up = 1'b0;
		endcase
		return up;
	endfunction
endpackage

// ===== hdl/float_round_to_integral_core.sv =====
`timescale 1ns / 1ps
// Throughput: one transaction per cycle while the skid register is empty; the
// rounding logic sits between the input ports and the result register (a skid
// register absorbs stalls, and in_ready drops while it holds a result).
// Reset: arst_n clears the valid flags only; payload registers are not reset.
module float_round_to_integral_core import frti_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [ValueWidth-1:0] value_bits,
	input  logic                  is_double,
	input  logic [OpWidth-1:0]    opcode,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [ValueWidth-1:0] result_bits
);
	logic [ValueWidth-1:0] res_c, res_s1, skid_q;
	logic                  v_s1, skid_v_q;

	frti_round u_round (.value_bits(value_bits), .is_double(is_double), .opcode(opcode),
		.result_bits(res_c));

	assign in_ready    = ~skid_v_q;
	assign out_valid   = v_s1;
	assign result_bits = res_s1;

	// Advance the result register; park a stalled result in the skid register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (!v_s1 || out_ready) begin
				v_s1 <= skid_v_q | in_valid;
				skid_v_q <= 1'b0;
			end else if (in_valid && in_ready) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!v_s1 || out_ready)
			res_s1 <= skid_v_q ? skid_q : res_c;
		if (in_valid && in_ready && v_s1 && !out_ready)
			skid_q <= res_c;
	end
endmodule

// ===== hdl/frti_round.sv =====
`timescale 1ns / 1ps
module frti_round import frti_pkg::*; (
	input  logic [ValueWidth-1:0] value_bits,
	input  logic                  is_double,
	input  logic [OpWidth-1:0]    opcode,
	output logic [ValueWidth-1:0] result_bits
);
	logic [63:0] u, r, mask, rem, half, trunc, tsum;
	logic [63:0] signbit, emaxv, bias, mag;
	logic [10:0] e;
	logic [5:0]  mb;
	logic [6:0]  f;
	logic [10:0] ex;
	logic        neg, lsb, up, nan_inf, below_one, big;

	// Decode the operand fields for the selected format and round to an integral value
	always_comb begin
		u  = is_double ? value_bits : {32'd0, value_bits[31:0]};
		mb = is_double ? 6'd52 : 6'd23;
		signbit = is_double ? 64'h8000_0000_0000_0000 : 64'h0000_0000_8000_0000;
		emaxv   = is_double ? 64'd2047 : 64'd255;
		bias    = is_double ? 64'd1023 : 64'd127;
		mag = u & (signbit - 64'd1);
		e   = 11'(mag >> mb);
		neg = (u & signbit) != 64'd0;
		nan_inf = {53'd0, e} == emaxv;
		below_one = {53'd0, e} < bias;
		ex = e - 11'(bias);
		big = ex >= {5'd0, mb};
		f = 7'(mb) - 7'(ex);
		mask = (64'd1 << f) - 64'd1;
		rem  = mag & mask;
		half = 64'd1 << (f - 7'd1);
		trunc = mag & ~mask;
		lsb = (ex == 11'd0) ? 1'b1 : mag[f[5:0]];
		up = take_up(opcode, neg, rem > half, rem == half, lsb);
		tsum = trunc + (up ? (64'd1 << f) : 64'd0);
		r = u;
		if (nan_inf) begin
			if ((mag & ((64'd1 << mb) - 64'd1)) != 64'd0)
				r = u | (64'd1 << (mb - 6'd1));
		end else if (mag == 64'd0) begin
			r = u;
		end else if (below_one) begin
			r = (u & signbit) | (take_up(opcode, neg,
				({53'd0, e} == bias - 64'd1) && ((mag & ((64'd1 << mb) - 64'd1)) != 64'd0),
				({53'd0, e} == bias - 64'd1) && ((mag & ((64'd1 << mb) - 64'd1)) == 64'd0),
				1'b0) ? (bias << mb) : 64'd0);
		end else if (!big && rem != 64'd0) begin
			r = (u & signbit) | tsum;
		end
		result_bits = is_double ? r : {32'd0, r[31:0]};
	end
endmodule

// ===== hdl/frti_checker.sv =====
`timescale 1ns / 1ps
module frti_checker import frti_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  is_double,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [ValueWidth-1:0] result_bits
);
	// Hold a stalled result
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_bits))
		else $error("stalled result changed");
	// Assert out_valid in the next cycle whenever a transaction is accepted
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted transaction not shown");
	// Keep accepting while output drains
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |=> in_ready)
		else $error("input blocked after drain");
	// Single results accepted into an empty output keep upper bits zero
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !is_double && !out_valid |=> result_bits[63:32] == 32'd0)
		else $error("binary32 upper bits set");
endmodule

bind float_round_to_integral_core frti_checker u_frti_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.is_double(is_double), .out_valid(out_valid), .out_ready(out_ready),
	.result_bits(result_bits));

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
	import frti_pkg::*;

	typedef struct packed {
		logic [ValueWidth-1:0] value;
		logic                  dbl;
		logic [OpWidth-1:0]    op;
	} round_req_t;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic [ValueWidth-1:0] value_bits;
	logic                  is_double;
	logic [OpWidth-1:0]    opcode;
	logic                  out_valid;
	logic                  out_ready;
	logic [ValueWidth-1:0] result_bits;

	round_req_t      pending_reqs[$];
	logic [63:0]     expected_rounded[$];
	int              err_count;
	int              cycle_count;
	int              send_gap;
	int              recv_gap;
	bit              stim_done;
	bit              drain_hold;
	bit              in_acc;

	float_round_to_integral_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.value_bits(value_bits), .is_double(is_double), .opcode(opcode),
		.out_valid(out_valid), .out_ready(out_ready), .result_bits(result_bits)
	);

	// Decide whether the truncated magnitude steps up
	function automatic bit bump_up(logic [2:0] op, bit neg, bit above, bit tie, bit lsb);
		case (op)
			OP_NEAR_AWAY: return above | tie;
			OP_AWAY:      return 1'b1;
			OP_EVEN:      return above | (tie & lsb);
			OP_ODD:       return above | (tie & ~lsb);
			OP_CEIL:      return ~neg;
			OP_FLOOR:     return neg;
			default:      return 1'b0;
		endcase
	endfunction

	// Round a bit pattern of given exponent and fraction widths
	function automatic logic [63:0] round_integral(logic [63:0] u, int ebits, int mbits,
			logic [2:0] op);
		logic [63:0] sgn, emax, bias, mag, e, frac, msk, rem, half, trunc;
		bit neg, up;
		int ex, f;
		sgn = 64'd1 << (ebits + mbits);
		emax = (64'd1 << ebits) - 1;
		bias = emax >> 1;
		mag = u & (sgn - 1);
		e = mag >> mbits;
		frac = mag & ((64'd1 << mbits) - 1);
		neg = (u & sgn) != 0;
		if (e == emax)
			return (frac != 0) ? (u | (64'd1 << (mbits - 1))) : u;
		if (mag == 0)
			return u;
		if (e < bias) begin
			up = bump_up(op, neg, (e == bias - 1) && frac != 0, (e == bias - 1) && frac == 0,
				1'b0);
			return (u & sgn) | (up ? (bias << mbits) : 64'd0);
		end
		if (e - bias >= mbits)
			return u;
		ex = int'(e - bias);
		f = mbits - ex;
		msk = (64'd1 << f) - 1;
		rem = mag & msk;
		half = 64'd1 << (f - 1);
		trunc = mag & ~msk;
		if (rem == 0)
			return u;
		if (bump_up(op, neg, rem > half, rem == half, (ex == 0) ? 1'b1 : mag[f]))
			trunc = trunc + (64'd1 << f);
		return (u & sgn) | trunc;
	endfunction

	function automatic logic [63:0] predict_rounding(round_req_t r);
		logic [63:0] t;
		if (r.dbl)
			return round_integral(r.value, 11, 52, r.op);
		t = round_integral({32'd0, r.value[31:0]}, 8, 23, r.op);
		return {32'd0, t[31:0]};
	endfunction

	// Build a value near the integral boundary with random content
	function automatic logic [63:0] boundary_value(bit dbl);
		logic [63:0] v;
		v = {$urandom, $urandom};
		if (dbl)
			v[62:52] = 11'd1023 + 11'($urandom_range(0, 55)) - 11'd3;
		else
			v[30:23] = 8'd127 + 8'($urandom_range(0, 26)) - 8'd3;
		if ($urandom_range(0, 3) == 0) begin
			// clear low fraction bits to land on ties and exact values
			v = v & ~((64'd1 << $urandom_range(0, 50)) - 1);
			if ($urandom_range(0, 1)) v[$urandom_range(0, dbl ? 51 : 22)] = 1'b1;
		end
		return v;
	endfunction

	task automatic push_req(logic [63:0] v, bit d, logic [2:0] o);
		round_req_t r;
		r.value = v;
		r.dbl = d;
		r.op = o;
		pending_reqs.push_back(r);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		logic [63:0] v;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		// directed: every opcode on signed halves, ties, extremes and specials
		for (int o = 0; o < 8; o++) begin
			push_req(64'h3FE0_0000_0000_0000, 1'b1, 3'(o));
			push_req(64'hBFF8_0000_0000_0000, 1'b1, 3'(o));
			push_req(64'hFFFF_FFFF_BE99_999A, 1'b0, 3'(o));
		end
		push_req(64'h7FF0_0000_0000_0000, 1'b1, OP_CEIL);
		push_req(64'hFFF0_0000_0001_0000, 1'b1, OP_FLOOR);
		push_req(64'h0000_0000_7F80_0001, 1'b0, OP_EVEN);
		push_req(64'h0000_0000_8000_0000, 1'b0, OP_AWAY);
		push_req(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, OP_ODD);
		push_req(64'h0000_0000_0000_0001, 1'b1, OP_AWAY);
		push_req(64'h4330_0000_0000_0001, 1'b1, OP_AWAY);
		push_req(64'h0000_0000_4B00_0001, 1'b0, OP_CEIL);
		// random: mostly near the integral boundary
		for (int i = 0; i < 2000; i++) begin
			if (i == 1000) begin
				// hold until everything issued so far has drained
				wait (pending_reqs.size() == 0);
				drain_hold = 1'b1;
				wait (expected_rounded.size() == 0 && !in_valid);
				drain_hold = 1'b0;
			end
			v = {$urandom, $urandom};
			if ($urandom_range(0, 4) != 0) v = boundary_value(i[0]);
			push_req(v, i[0] ^ ($urandom_range(0, 7) == 0), 3'($urandom_range(0, 7)));
			if (pending_reqs.size() > 4)
				wait (pending_reqs.size() <= 4);
		end
		stim_done = 1'b1;
	end

	// Record each input transaction at the edge that accepts it
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_acc <= 1'b0;
		end else begin
			in_acc <= in_valid && in_ready;
			if (in_valid && in_ready)
				expected_rounded.push_back(predict_rounding({value_bits, is_double, opcode}));
		end
	end

	// Drive transactions from the pending queue
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			value_bits <= '0;
			is_double <= 1'b0;
			opcode <= OP_NEAR_AWAY;
			send_gap <= 0;
		end else if (!in_valid || in_acc) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				in_valid <= 1'b0;
			end else if (pending_reqs.size() > 0 && !drain_hold) begin
				round_req_t r;
				r = pending_reqs.pop_front();
				in_valid <= 1'b1;
				value_bits <= r.value;
				is_double <= r.dbl;
				opcode <= r.op;
				send_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Check each result transaction against the oldest prediction
	always @(posedge clk) begin
		logic [63:0] want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_rounded.size() == 0) begin
				$display("%0t: unexpected result %h", $time, result_bits);
				err_count++;
			end else begin
				want = expected_rounded.pop_front();
				if (result_bits !== want) begin
					$display("%0t: result_bits expected %h actual %h", $time, want,
						result_bits);
					err_count++;
				end
			end
		end
	end

	// Stall the result side at random
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_gap <= 0;
		end else if (recv_gap > 0) begin
			recv_gap <= recv_gap - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if (out_valid && out_ready)
				recv_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
		end
	end

	// End of run and watchdog
	initial begin
		err_count = 0;
		cycle_count = 0;
		stim_done = 1'b0;
		drain_hold = 1'b0;
		fork
			begin
				wait (stim_done && pending_reqs.size() == 0);
				@(negedge clk);
				while (in_valid || expected_rounded.size() != 0) @(negedge clk);
				repeat (20) @(posedge clk);
				if (err_count == 0)
					$display("DONE: 0 errors");
				else
					$display("DONE: errors detected");
				$finish;
			end
			begin
				while (cycle_count < 400000) begin
					@(posedge clk);
					cycle_count++;
				end
				$display("DONE: errors detected");
				$finish;
			end
		join
	end
endmodule
